FILE: rtl/core/ksce_pkg.sv
// shared types and constants for the k-subset colex enumerator
package ksce_pkg;

  localparam int MAX_K = 8;
  localparam int MAX_N = 256;

  localparam int POS_W = 8;
  localparam int KW    = $clog2(MAX_K + 1);
  localparam int NW    = $clog2(MAX_N + 1);
  localparam int JW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_NEXT    = 2'd1,
    ACT_MAP_WR  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    CFG_SET_SIZE    = 2'd0,
    CFG_SUBSET_SIZE = 2'd1,
    CFG_USE_REMAP   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_EXHAUST
  } state_t;

  typedef struct packed {
    logic restart;
    logic map_wr;
    logic init;
    logic scan_clr;
    logic scan_inc;
    logic advance;
    logic emit;
    logic exhaust;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic fresh;
    logic pos0_ge;
    logic scan_stop;
    logic emit_last;
  } status_t;

endpackage

FILE: rtl/core/ksce_ctrl.sv
// controller state machine for the k-subset colex enumerator
module ksce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_action,
  input  ksce_pkg::status_t sts,
  output ksce_pkg::cmd_t    cmd,
  output logic              busy
);
  import ksce_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_action == ACT_RESTART) begin
            cmd.restart = 1'b1;
          end else if (in_action == ACT_MAP_WR) begin
            cmd.map_wr = 1'b1;
          end else if (in_action == ACT_NEXT) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        priority if (sts.invalid || (!sts.fresh && sts.pos0_ge)) begin
          state_nxt = ST_EXHAUST;
        end else if (sts.fresh) begin
          cmd.init  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // walk up until a position that can grow
        if (sts.scan_stop) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXHAUST: begin
        cmd.exhaust = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/ksce_dp.sv
// datapath: positions, scan index, remap memory and result register
module ksce_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ksce_pkg::cmd_t             cmd,
  input  logic [8:0]                 set_size,
  input  logic [3:0]                 subset_size,
  input  logic                       use_remap,
  input  logic [7:0]                 map_index,
  input  logic [7:0]                 map_value,
  output ksce_pkg::status_t          sts,
  output logic                       out_strobe,
  output logic [7:0]                 out_element,
  output logic                       out_found,
  output logic                       out_last_of_subset
);
  import ksce_pkg::*;

  logic [POS_W-1:0] pos_r [MAX_K];
  logic [POS_W-1:0] pos_nxt [MAX_K];
  logic             fresh_r;
  logic [JW-1:0]    j_r;
  logic [JW-1:0]    e_r;

  logic [7:0]       remap_mem [MAX_N];
  logic [7:0]       mem_q_r;
  logic [POS_W-1:0] idx_r;
  logic             in_range_r;
  logic             sel_map_r;
  logic             strobe_r;
  logic             found_r;
  logic             last_r;

  logic [KW-1:0]    k_sat;
  logic [NW-1:0]    n_sat;
  logic [MAX_K-1:0] gap;
  logic [POS_W-1:0] pos_e;
  logic             e_last;

  assign k_sat = (32'(subset_size) > MAX_K) ? KW'(MAX_K) : KW'(subset_size);
  assign n_sat = (32'(set_size) > MAX_N) ? NW'(MAX_N) : NW'(set_size);

  // per lane: next position sits more than one above this one
  always_comb begin
    for (int i = 0; i < MAX_K - 1; i++) begin
      gap[i] = ({1'b0, pos_r[i+1]} > ({1'b0, pos_r[i]} + 9'd1));
    end
    gap[MAX_K-1] = 1'b1;
  end

  assign pos_e  = pos_r[e_r];
  assign e_last = (32'(e_r) == 32'(k_sat) - 1);

  assign sts.invalid   = (n_sat == '0) || (k_sat == '0) || (32'(n_sat) < 32'(k_sat));
  assign sts.fresh     = fresh_r;
  assign sts.pos0_ge   = (32'(pos_r[0]) + 32'(k_sat)) >= 32'(n_sat);
  assign sts.scan_stop = (32'(j_r) == 32'(k_sat) - 1) || gap[j_r];
  assign sts.emit_last = e_last;

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      pos_nxt[i] = pos_r[i];
      if (cmd.restart) begin
        pos_nxt[i] = '0;
      end else if (cmd.init) begin
        if (i < 32'(k_sat)) begin
          pos_nxt[i] = POS_W'(i);
        end
      end else if (cmd.advance) begin
        if (i < 32'(j_r)) begin
          pos_nxt[i] = POS_W'(i);
        end else if (i == 32'(j_r)) begin
          pos_nxt[i] = pos_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_K; i++) begin
        pos_r[i] <= '0;
      end
      fresh_r  <= 1'b1;
      j_r      <= '0;
      e_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      strobe_r <= cmd.emit || cmd.exhaust;
      if (cmd.restart) begin
        fresh_r <= 1'b1;
      end else if (cmd.init) begin
        fresh_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        j_r <= '0;
      end else if (cmd.scan_inc) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.init || cmd.advance) begin
        e_r <= '0;
      end else if (cmd.emit) begin
        e_r <= e_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_wr && (32'(map_index) < MAX_N)) begin
      remap_mem[AW'(map_index)] <= map_value;
    end
    mem_q_r <= remap_mem[AW'(pos_e)];
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (cmd.exhaust) begin
      idx_r      <= '0;
      in_range_r <= 1'b1;
      sel_map_r  <= 1'b0;
      found_r    <= 1'b0;
      last_r     <= 1'b1;
    end else if (cmd.emit) begin
      idx_r      <= pos_e;
      in_range_r <= (32'(pos_e) < MAX_N);
      sel_map_r  <= use_remap;
      found_r    <= 1'b1;
      last_r     <= e_last;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_element        = sel_map_r ? (in_range_r ? mem_q_r : 8'd0) : 8'(idx_r);
  assign out_found          = found_r;
  assign out_last_of_subset = last_r;

endmodule

FILE: rtl/core/k_subset_colex_enumerator_unit.sv
// top level of the k-subset colex enumerator: config registers, controller, datapath
//   Items: raise start with in_action, in_map_index, in_map_value; the word is
//   taken on a clock edge where start is high and busy is low.
//   in_action restart clears the position, remap write loads one table entry;
//   both produce no result and leave busy low.
//   in_action next emits one subset as k result words, lowest index first,
//   out_last_of_subset on the final one, or one word with out_found low when
//   the enumeration is exhausted or n, k do not allow a subset.
//   Results: each word is on out_* for one cycle, marked by out_strobe; the
//   receiver cannot stall, so every word must be taken as it appears.
//   Steps for next: after a restart it goes check, then emit for the k words;
//   otherwise check, scan up to the position j it stops at (at most k - 1),
//   then emit; the scan steps one position a cycle and the remap memory port
//   gives one element a cycle. The final word is on the ports in the cycle in
//   which busy falls. Exhaustion passes through the check and exhaust states
//   with busy high.
//   Config: cfg_valid/cfg_ready write set_size, subset_size, use_remap by
//   cfg_index; cfg_ready is always high. Write only while the block is idle.
//   Reset: synchronous, active low; n = 0, k = 1, remap off, fresh start.
//   The remap table is not cleared and must be written before it is read.
module k_subset_colex_enumerator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_action,
  input  logic [7:0] in_map_index,
  input  logic [7:0] in_map_value,
  output logic       out_strobe,
  output logic [7:0] out_element,
  output logic       out_found,
  output logic       out_last_of_subset,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import ksce_pkg::*;

  logic [8:0] set_size_r;
  logic [3:0] subset_size_r;
  logic       use_remap_r;
  cmd_t       cmd;
  status_t    sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r    <= '0;
      subset_size_r <= 4'd1;
      use_remap_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SET_SIZE) begin
        set_size_r <= cfg_data;
      end else if (cfg_index == CFG_SUBSET_SIZE) begin
        subset_size_r <= cfg_data[3:0];
      end else if (cfg_index == CFG_USE_REMAP) begin
        use_remap_r <= cfg_data[0];
      end
    end
  end

  ksce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  ksce_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .set_size           (set_size_r),
    .subset_size        (subset_size_r),
    .use_remap          (use_remap_r),
    .map_index          (in_map_index),
    .map_value          (in_map_value),
    .sts                (sts),
    .out_strobe         (out_strobe),
    .out_element        (out_element),
    .out_found          (out_found),
    .out_last_of_subset (out_last_of_subset)
  );

  // exhaustion word is always a single, marked, zero word
  a_exhaust_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_last_of_subset && (out_element == 8'd0))
    else $error("exhaustion word malformed");

  // restart and remap write never cause a result
  a_quiet_items: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action != ACT_NEXT) |=> !out_strobe)
    else $error("result after a non-next item");

  // a next item keeps the block busy while it works
  a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_NEXT) |=> busy ##1 busy)
    else $error("busy dropped too early after next");

endmodule

FILE: tb/tb_k_subset_colex_enumerator_unit.sv
// self-checking testbench for the k-subset colex enumerator unit
`timescale 1ns / 100ps

module tb_k_subset_colex_enumerator_unit;
  import ksce_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS   = 210;
  localparam int SETTLE_CYCLES = 2 * MAX_K + 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_PHASE    = 2;

  typedef struct {
    logic [1:0] action;
    logic [7:0] map_index;
    logic [7:0] map_value;
    bit         drain_first;
  } stim_t;

  typedef struct {
    logic [7:0] elem;
    logic       found;
    logic       last_word;
  } subset_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_action = 2'd0;
  logic [7:0] in_map_index = 8'd0;
  logic [7:0] in_map_value = 8'd0;
  logic       out_strobe;
  logic [7:0] out_element;
  logic       out_found;
  logic       out_last_of_subset;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [8:0] cfg_data = 9'd0;

  // shadow of the block state
  logic [8:0] set_size_q = 9'd0;
  logic [3:0] subset_size_q = 4'd1;
  logic       remap_q = 1'b0;
  logic [7:0] pos_q [MAX_K];
  logic       fresh_q = 1'b1;
  logic [7:0] remap_mem [MAX_N];

  stim_t        pending_items[$];
  subset_word_t expected_words[$];
  stim_t        cur_item;
  bit           item_taken;
  bit           gaps_on = 1'b1;
  bit           map_loaded [MAX_N];
  int           error_count = 0;
  int           cycle_count = 0;
  int           items_queued = 0;

  k_subset_colex_enumerator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_map_index      (in_map_index),
    .in_map_value      (in_map_value),
    .out_strobe        (out_strobe),
    .out_element       (out_element),
    .out_found         (out_found),
    .out_last_of_subset(out_last_of_subset),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // works out the words one accepted item produces and advances the shadow state
  task automatic advance_colex(input stim_t it);
    int n, k, i, j;
    bit dry;
    subset_word_t w;
    case (it.action)
      ACT_RESTART: begin
        fresh_q = 1'b1;
        for (i = 0; i < MAX_K; i++) pos_q[i] = 8'd0;
      end
      ACT_MAP_WR: remap_mem[it.map_index] = it.map_value;
      ACT_NEXT: begin
        n = (set_size_q > MAX_N) ? MAX_N : int'(set_size_q);
        k = (subset_size_q > MAX_K) ? MAX_K : int'(subset_size_q);
        dry = (n == 0 || k == 0 || n < k);
        if (!dry && fresh_q) begin
          fresh_q = 1'b0;
          for (i = 0; i < k; i++) pos_q[i] = i[7:0];
        end else if (!dry) begin
          if (pos_q[0] >= n - k) begin
            dry = 1'b1;
          end else begin
            j = 0;
            // lowest position with room above it
            while (j < k - 1 && pos_q[j + 1] <= pos_q[j] + 1) j++;
            pos_q[j] = pos_q[j] + 8'd1;
            for (i = 0; i < j; i++) pos_q[i] = i[7:0];
          end
        end
        if (dry) begin
          w.elem = 8'd0;
          w.found = 1'b0;
          w.last_word = 1'b1;
          expected_words = {expected_words, w};
        end else begin
          for (i = 0; i < k; i++) begin
            w.elem = remap_q ? remap_mem[pos_q[i]] : pos_q[i];
            w.found = 1'b1;
            w.last_word = (i == k - 1);
            expected_words = {expected_words, w};
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver: acceptance seen at the rising edge, next word put out at the falling edge
  always begin
    @(posedge clk);
    item_taken = 1'b0;
    if (rst_n && start && !busy) begin
      advance_colex(cur_item);
      item_taken = 1'b1;
    end
    @(negedge clk);
    if (!start || item_taken) begin
      if (rst_n && pending_items.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 14)
          && !(pending_items[0].drain_first && (expected_words.size() != 0 || busy))) begin
        cur_item = pending_items.pop_front();
        start <= 1'b1;
        in_action <= cur_item.action;
        in_map_index <= cur_item.map_index;
        in_map_value <= cur_item.map_value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    subset_word_t w;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word element %0d found %0b last %0b", $time,
                 out_element, out_found, out_last_of_subset);
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_element !== w.elem) begin
          $display("%0t: element expected %0d actual %0d", $time, w.elem, out_element);
          error_count++;
        end
        if (out_found !== w.found) begin
          $display("%0t: found expected %0b actual %0b", $time, w.found, out_found);
          error_count++;
        end
        if (out_last_of_subset !== w.last_word) begin
          $display("%0t: last_of_subset expected %0b actual %0b", $time, w.last_word,
                   out_last_of_subset);
          error_count++;
        end
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic [7:0] val, input bit drain);
    stim_t it;
    it.action = act;
    it.map_index = idx;
    it.map_value = val;
    it.drain_first = drain;
    if (act == ACT_MAP_WR) map_loaded[idx] = 1'b1;
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic push_random(input logic [1:0] act, input bit drain);
    push_item(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), drain);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || expected_words.size() != 0 || start || busy);
    // restart and table writes give no word, so let them settle too
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    case (idx)
      CFG_SET_SIZE:    set_size_q = val;
      CFG_SUBSET_SIZE: subset_size_q = val[3:0];
      CFG_USE_REMAP:   remap_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [8:0] n, input logic [3:0] k, input logic remap);
    write_reg(CFG_SET_SIZE, n);
    write_reg(CFG_SUBSET_SIZE, {5'd0, k});
    write_reg(CFG_USE_REMAP, {8'd0, remap});
  endtask

  initial begin
    int phase, len, r, i;
    logic [8:0] n;
    logic [3:0] k;
    logic remap;

    for (i = 0; i < MAX_K; i++) pos_q[i] = 8'd0;
    for (i = 0; i < MAX_N; i++) begin
      remap_mem[i] = 8'd0;
      map_loaded[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty set after reset, ignored action, table extremes
    push_random(ACT_NEXT, 1'b0);
    push_random(ACT_UNUSED, 1'b0);
    push_item(ACT_MAP_WR, 8'd0, 8'hFF, 1'b0);
    push_item(ACT_MAP_WR, 8'd1, 8'h00, 1'b0);
    push_item(ACT_MAP_WR, 8'd2, 8'h5A, 1'b0);
    push_item(ACT_MAP_WR, 8'd3, 8'hA5, 1'b0);
    push_item(ACT_MAP_WR, 8'd255, 8'h3C, 1'b0);
    push_random(ACT_NEXT, 1'b0);
    wait_idle();

    // full remapped walk of 2 out of 4, then exhaustion twice
    set_all(9'd4, 4'd2, 1'b1);
    push_random(ACT_RESTART, 1'b0);
    repeat (8) push_random(ACT_NEXT, 1'b0);
    wait_idle();

    // set smaller than the subset, then k of zero
    set_all(9'd3, 4'd4, 1'b0);
    push_random(ACT_NEXT, 1'b0);
    wait_idle();
    write_reg(CFG_SUBSET_SIZE, 9'd0);
    push_random(ACT_NEXT, 1'b0);
    wait_idle();

    // oversized n and k saturate
    set_all(9'd511, 4'd15, 1'b0);
    push_random(ACT_RESTART, 1'b0);
    repeat (2) push_random(ACT_NEXT, 1'b0);
    wait_idle();

    // shrink n mid-walk, the scan goes on from the stored positions
    set_all(9'd9, 4'd8, 1'b0);
    repeat (2) push_random(ACT_NEXT, 1'b0);
    wait_idle();

    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) n = 9'd0;
      else if (r < 65) n = 9'($urandom_range(1, 9));
      else if (r < 80) n = 9'($urandom_range(10, 24));
      else if (r < 90) n = 9'd256;
      else n = 9'($urandom_range(257, 511));
      r = $urandom_range(0, 99);
      if (r < 80) k = 4'($urandom_range(1, 5));
      else if (r < 90) k = 4'($urandom_range(6, 8));
      else if (r < 95) k = 4'd0;
      else k = 4'($urandom_range(9, 15));
      remap = (n <= 16) && ($urandom_range(0, 99) < 45);
      set_all(n, k, remap);
      gaps_on = (phase != LONG_PHASE);

      if (remap) begin
        // every entry the walk can touch gets written first
        for (i = 0; i < n; i++)
          if (!map_loaded[i]) push_item(ACT_MAP_WR, i[7:0], 8'($urandom_range(0, 255)), 1'b0);
        push_random(ACT_RESTART, 1'b0);
      end else if ($urandom_range(0, 99) < 70) begin
        push_random(ACT_RESTART, 1'b0);
      end

      len = (phase == LONG_PHASE) ? 50 : $urandom_range(8, 30);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (phase == 1 && i == len / 2) push_random(ACT_NEXT, 1'b1);
        else if (r < 72) push_random(ACT_NEXT, 1'b0);
        else if (r < 80) push_random(ACT_RESTART, 1'b0);
        else if (r < 92) push_random(ACT_MAP_WR, 1'b0);
        else if (r < 97) push_random(ACT_UNUSED, 1'b0);
        else push_random(ACT_NEXT, 1'b1);
      end
      wait_idle();
      phase++;
    end

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ksce_pkg.sv
rtl/core/ksce_ctrl.sv
rtl/core/ksce_dp.sv
rtl/core/k_subset_colex_enumerator_unit.sv
tb/tb_k_subset_colex_enumerator_unit.sv
